/* design/cba_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// cba_pkg
// Types and constants shared by the contiguous block allocator modules.
// ----------------------------------------------------------------------------
package cba_pkg;

    localparam int BLOCK_SHIFT = 3;
    localparam int ID_W        = 8;
    localparam int SIZE_W      = 16;
    localparam int MODE_W      = 2;

    typedef enum logic [1:0] {
        MODE_ADD    = 2'd0,
        MODE_GET    = 2'd1,
        MODE_DELETE = 2'd2,
        MODE_DEFRAG = 2'd3
    } mode_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_ADD_SCAN,
        ST_ADD_FILL,
        ST_GET_SCAN,
        ST_DEL_SCAN,
        ST_PACK_SCAN,
        ST_PACK_ZERO,
        ST_LIST_SCAN,
        ST_RESULT,
        ST_WAIT_OUT
    } state_t;

    typedef struct packed {
        logic clr_ptr;
        logic step;
        logic add_scan;
        logic add_fill;
        logic get_scan;
        logic del_scan;
        logic pack_scan;
        logic pack_zero;
        logic list_scan;
        logic list_hold;
        logic emit_single;
        logic last_pending;
    } ctrl_t;

    typedef struct packed {
        logic scan_end;
        logic add_found;
        logic fill_end;
        logic get_done;
        logic zero_end;
        logic out_busy;
    } stat_t;

endpackage : cba_pkg
`default_nettype wire

/* design/cba_ram.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// cba_ram
// Generic RAM with one write port and one read port, and a registered read.
// ----------------------------------------------------------------------------
module cba_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule : cba_ram
`default_nettype wire

/* design/cba_ctrl.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// cba_ctrl
// Command sequencer of the allocator.
// ----------------------------------------------------------------------------
module cba_ctrl (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire logic            start,
    input  wire cba_pkg::mode_t  mode,
    input  wire logic            clear_busy,
    input  wire cba_pkg::stat_t  stat,
    output logic                 busy,
    output cba_pkg::ctrl_t       ctrl
);
    import cba_pkg::*;

    state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (start && !clear_busy) begin
                    unique case (mode)
                        MODE_ADD:    state_next = ST_ADD_SCAN;
                        MODE_GET:    state_next = ST_GET_SCAN;
                        MODE_DELETE: state_next = ST_DEL_SCAN;
                        MODE_DEFRAG: state_next = ST_PACK_SCAN;
                        default:     state_next = ST_IDLE;
                    endcase
                end
            end
            ST_ADD_SCAN: begin
                if (stat.add_found) state_next = ST_ADD_FILL;
                else if (stat.scan_end) state_next = ST_RESULT;
            end
            ST_ADD_FILL: if (stat.fill_end) state_next = ST_RESULT;
            ST_GET_SCAN: if (stat.get_done) state_next = ST_RESULT;
            ST_DEL_SCAN: if (stat.scan_end) state_next = ST_LIST_SCAN;
            ST_PACK_SCAN: if (stat.scan_end) state_next = ST_PACK_ZERO;
            ST_PACK_ZERO: if (stat.zero_end) state_next = ST_LIST_SCAN;
            ST_LIST_SCAN: begin
                if (!stat.out_busy && stat.scan_end) state_next = ST_WAIT_OUT;
            end
            ST_RESULT: if (!stat.out_busy) state_next = ST_WAIT_OUT;
            ST_WAIT_OUT: if (!stat.out_busy) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        ctrl = '0;
        busy = (state_reg != ST_IDLE) || clear_busy;
        unique case (state_reg)
            ST_IDLE: ctrl.clr_ptr = 1'b1;
            ST_ADD_SCAN: begin
                ctrl.add_scan = 1'b1;
                ctrl.step = 1'b1;
            end
            ST_ADD_FILL: begin
                ctrl.add_fill = 1'b1;
                ctrl.step = 1'b1;
            end
            ST_GET_SCAN: begin
                ctrl.get_scan = 1'b1;
                ctrl.step = 1'b1;
            end
            ST_DEL_SCAN: begin
                ctrl.del_scan = 1'b1;
                ctrl.step = 1'b1;
                ctrl.clr_ptr = stat.scan_end;
            end
            ST_PACK_SCAN: begin
                ctrl.pack_scan = 1'b1;
                ctrl.step = 1'b1;
            end
            ST_PACK_ZERO: begin
                ctrl.pack_zero = 1'b1;
                ctrl.step = 1'b1;
                ctrl.clr_ptr = stat.zero_end;
            end
            ST_LIST_SCAN: begin
                ctrl.list_scan = !stat.out_busy;
                ctrl.step = !stat.out_busy;
                ctrl.list_hold = stat.out_busy;
            end
            ST_RESULT: ctrl.emit_single = !stat.out_busy;
            ST_WAIT_OUT: ctrl.last_pending = 1'b1;
            default: ctrl = '0;
        endcase
    end
endmodule : cba_ctrl
`default_nettype wire

/* design/cba_dp.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// cba_dp
// Block store, scan pointers, run tracking and output register.
// ----------------------------------------------------------------------------
module cba_dp #(
    parameter int NUM_BLOCKS = 64
) (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic                        start,
    input  wire logic [cba_pkg::MODE_W-1:0]  in_mode,
    input  wire logic [cba_pkg::ID_W-1:0]    in_id,
    input  wire logic [cba_pkg::SIZE_W-1:0]  in_size,
    input  wire cba_pkg::ctrl_t              ctrl,
    output cba_pkg::stat_t                   stat,
    output logic                             clear_busy,
    output logic                             out_valid,
    input  wire logic                        out_ready,
    output logic [cba_pkg::ID_W-1:0]         out_owner,
    output logic [5:0]                       out_first,
    output logic [5:0]                       out_last_block,
    output logic                             out_success,
    output logic                             out_last
);
    import cba_pkg::*;

    localparam int AW = $clog2(NUM_BLOCKS);
    localparam int CW = AW + 1;
    localparam int NW = SIZE_W - BLOCK_SHIFT + 1;

    // read pointer runs one ahead of the registered data
    logic [CW-1:0] rp_reg, rp_next;
    logic [CW-1:0] dp_reg, dp_next;
    logic          dv_reg, dv_next;
    logic [CW-1:0] wp_reg, wp_next;
    logic [CW-1:0] run_reg, run_next;
    logic [CW-1:0] start_reg, start_next;
    logic          found_reg, found_next;
    logic [ID_W-1:0] id_reg;
    logic [NW-1:0] need_reg;
    logic          ok_reg;
    logic [CW-1:0] clr_reg, clr_next;

    logic [ID_W-1:0] o_owner_reg, o_owner_next;
    logic [5:0]      o_first_reg, o_first_next;
    logic [5:0]      o_lastb_reg, o_lastb_next;
    logic            o_succ_reg, o_succ_next;
    logic            o_last_reg, o_last_next;
    logic            o_valid_reg, o_valid_next;
    logic            held_reg, held_next;
    logic            open_reg, open_next;
    logic [ID_W-1:0] h_owner_reg, h_owner_next;
    logic [5:0]      h_first_reg, h_first_next;
    logic [5:0]      h_lastb_reg, h_lastb_next;

    logic            we;
    logic [AW-1:0]   waddr;
    logic [ID_W-1:0] wdata;
    logic [ID_W-1:0] rdata;

    // get keeps its last match in run_reg, add derives the end from need
    logic            get_mode_reg;
    logic [5:0]      single_last;

    cba_ram #(.WIDTH(ID_W), .DEPTH(NUM_BLOCKS)) u_ram (
        .aclk  (aclk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .raddr (rp_reg[AW-1:0]),
        .rdata (rdata)
    );

    logic [NW-1:0] need_in;
    logic          rd_end;
    logic [CW-1:0] run_inc;
    logic          d_end;
    logic          out_free;

    assign need_in = NW'((in_size >> BLOCK_SHIFT)) + NW'(in_size[BLOCK_SHIFT-1:0] != '0);
    assign rd_end  = (rp_reg == CW'(NUM_BLOCKS));
    assign run_inc = run_reg + CW'(1);
    assign d_end   = dv_reg && (dp_reg == CW'(NUM_BLOCKS - 1));
    assign out_free = !o_valid_reg || out_ready;
    assign clear_busy = (clr_reg != CW'(NUM_BLOCKS));
    assign single_last = get_mode_reg ? 6'(run_reg)
                                      : 6'(start_reg + CW'(need_reg) - CW'(1));

    always_ff @(posedge aclk) begin
        if (start) begin
            id_reg   <= in_id;
            need_reg <= need_in;
            ok_reg   <= (in_size != '0) && (in_id != '0) && (need_in <= NW'(NUM_BLOCKS));
            get_mode_reg <= (in_mode == MODE_GET);
        end
    end

    always_comb begin
        rp_next = rp_reg;
        dp_next = dp_reg;
        dv_next = 1'b0;
        wp_next = wp_reg;
        run_next = run_reg;
        start_next = start_reg;
        found_next = found_reg;
        clr_next = clr_reg;
        we = 1'b0;
        waddr = dp_reg[AW-1:0];
        wdata = '0;
        stat = '0;
        o_owner_next = o_owner_reg;
        o_first_next = o_first_reg;
        o_lastb_next = o_lastb_reg;
        o_succ_next = o_succ_reg;
        o_last_next = o_last_reg;
        o_valid_next = o_valid_reg && !out_ready;
        held_next = held_reg;
        open_next = open_reg;
        h_owner_next = h_owner_reg;
        h_first_next = h_first_reg;
        h_lastb_next = h_lastb_reg;

        stat.out_busy = !out_free;
        stat.scan_end = d_end;

        if (clear_busy) begin
            we = 1'b1;
            waddr = clr_reg[AW-1:0];
            clr_next = clr_reg + CW'(1);
        end

        if (ctrl.step && !rd_end) begin
            rp_next = rp_reg + CW'(1);
            dv_next = 1'b1;
            dp_next = rp_reg;
        end

        // unconsumed block is read again once the output frees up
        if (ctrl.list_hold && dv_reg) begin
            rp_next = dp_reg;
        end

        if (ctrl.clr_ptr) begin
            rp_next = '0;
            dv_next = 1'b0;
            wp_next = '0;
            run_next = '0;
            found_next = 1'b0;
            held_next = 1'b0;
            open_next = 1'b0;
        end

        if (ctrl.add_scan) begin
            stat.scan_end = d_end || !ok_reg;
            if (dv_reg && ok_reg) begin
                if (rdata == '0) begin
                    run_next = run_inc;
                    if (run_inc == CW'(need_reg)) begin
                        stat.add_found = 1'b1;
                        found_next = 1'b1;
                        start_next = dp_reg + CW'(1) - CW'(need_reg);
                        wp_next = dp_reg + CW'(1) - CW'(need_reg);
                    end
                end else begin
                    run_next = '0;
                end
            end
        end

        if (ctrl.add_fill) begin
            we = 1'b1;
            waddr = wp_reg[AW-1:0];
            wdata = id_reg;
            wp_next = wp_reg + CW'(1);
            stat.fill_end = (wp_reg + CW'(1) == start_reg + CW'(need_reg));
        end

        if (ctrl.get_scan) begin
            stat.get_done = d_end || (id_reg == '0);
            if (dv_reg && id_reg != '0) begin
                if (rdata == id_reg) begin
                    if (!found_reg) begin
                        found_next = 1'b1;
                        start_next = dp_reg;
                    end
                    run_next = dp_reg;
                end else if (found_reg) begin
                    stat.get_done = 1'b1;
                end
            end
        end

        if (ctrl.del_scan && dv_reg && rdata == id_reg) begin
            we = 1'b1;
            waddr = dp_reg[AW-1:0];
            wdata = '0;
        end

        if (ctrl.pack_scan && dv_reg && rdata != '0) begin
            we = 1'b1;
            waddr = wp_reg[AW-1:0];
            wdata = rdata;
            wp_next = wp_reg + CW'(1);
        end

        if (ctrl.pack_zero) begin
            stat.zero_end = (wp_reg >= CW'(NUM_BLOCKS - 1));
            if (wp_reg < CW'(NUM_BLOCKS)) begin
                we = 1'b1;
                waddr = wp_reg[AW-1:0];
                wdata = '0;
                wp_next = wp_reg + CW'(1);
            end
        end

        // a closed run waits until the next run starts or the scan ends
        if (ctrl.list_scan && dv_reg) begin
            if (held_reg && open_reg && rdata == h_owner_reg) begin
                h_lastb_next = 6'(dp_reg);
            end else if (rdata != '0) begin
                if (held_reg) begin
                    o_valid_next = 1'b1;
                    o_owner_next = h_owner_reg;
                    o_first_next = h_first_reg;
                    o_lastb_next = h_lastb_reg;
                    o_succ_next = 1'b1;
                    o_last_next = 1'b0;
                end
                held_next = 1'b1;
                open_next = 1'b1;
                h_owner_next = rdata;
                h_first_next = 6'(dp_reg);
                h_lastb_next = 6'(dp_reg);
            end else begin
                open_next = 1'b0;
            end
        end

        if (ctrl.emit_single) begin
            o_valid_next = 1'b1;
            o_last_next = 1'b1;
            if (found_reg) begin
                o_owner_next = id_reg;
                o_first_next = 6'(start_reg);
                o_lastb_next = single_last;
                o_succ_next = 1'b1;
            end else begin
                o_owner_next = '0;
                o_first_next = '0;
                o_lastb_next = '0;
                o_succ_next = 1'b0;
            end
        end

        // last run of a list goes out when the scan is over
        if (ctrl.last_pending && held_reg && out_free) begin
            o_valid_next = 1'b1;
            o_owner_next = h_owner_reg;
            o_first_next = h_first_reg;
            o_lastb_next = h_lastb_reg;
            o_succ_next = 1'b1;
            o_last_next = 1'b1;
            held_next = 1'b0;
        end else if (ctrl.last_pending && !held_reg && o_valid_reg && out_ready) begin
            o_valid_next = 1'b0;
        end
        stat.out_busy = !out_free || (ctrl.last_pending && held_reg);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rp_reg <= '0;
            dv_reg <= 1'b0;
            wp_reg <= '0;
            run_reg <= '0;
            found_reg <= 1'b0;
            clr_reg <= '0;
            o_valid_reg <= 1'b0;
            held_reg <= 1'b0;
            open_reg <= 1'b0;
        end else begin
            rp_reg <= rp_next;
            dv_reg <= dv_next;
            wp_reg <= wp_next;
            run_reg <= run_next;
            found_reg <= found_next;
            clr_reg <= clr_next;
            o_valid_reg <= o_valid_next;
            held_reg <= held_next;
            open_reg <= open_next;
        end
        dp_reg <= dp_next;
        start_reg <= start_next;
        o_owner_reg <= o_owner_next;
        o_first_reg <= o_first_next;
        o_lastb_reg <= o_lastb_next;
        o_succ_reg <= o_succ_next;
        o_last_reg <= o_last_next;
        h_owner_reg <= h_owner_next;
        h_first_reg <= h_first_next;
        h_lastb_reg <= h_lastb_next;
    end

    assign out_valid      = o_valid_reg;
    assign out_owner      = o_owner_reg;
    assign out_first      = o_first_reg;
    assign out_last_block = o_lastb_reg;
    assign out_success    = o_succ_reg;
    assign out_last       = o_last_reg;
endmodule : cba_dp
`default_nettype wire

/* design/contiguous_block_allocator.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// contiguous_block_allocator
// First-fit contiguous block allocator with delete, get and compaction.
//
//  channel  dir  tdata fields (low bit up)          tuser / tlast
//  s_axis   in   mode, file_id, size_kb              -
//  m_axis   out  owner, first_block, last_block,     tlast = last
//                success
//
// one command at a time; get is one scan, add a scan and then a fill, delete
// a scan and then a run list, defragment a pack, a zero fill and a run list.
// after reset a clearing pass over all NUM_BLOCKS blocks runs before the first
// beat is taken. stalls on m_axis hold the result and pause the run list scan.
// ----------------------------------------------------------------------------
module contiguous_block_allocator #(
    parameter int NUM_BLOCKS = 64
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [31:0] s_axis_tdata,  // mode, file_id, size_kb
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [23:0]      m_axis_tdata,  // owner, first_block, last_block, success
    output logic             m_axis_tlast
);
    import cba_pkg::*;

    logic   busy;
    logic   start;
    logic   clear_busy;
    ctrl_t  ctrl;
    stat_t  stat;
    logic [ID_W-1:0] owner;
    logic [5:0] first_b, last_b;
    logic   success;

    assign s_axis_tready = !busy;
    assign start = s_axis_tvalid && s_axis_tready;

    cba_ctrl u_ctrl (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .start      (start),
        .mode       (mode_t'(s_axis_tdata[1:0])),
        .clear_busy (clear_busy),
        .stat       (stat),
        .busy       (busy),
        .ctrl       (ctrl)
    );

    cba_dp #(.NUM_BLOCKS(NUM_BLOCKS)) u_dp (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .start          (start),
        .in_mode        (s_axis_tdata[1:0]),
        .in_id          (s_axis_tdata[9:2]),
        .in_size        (s_axis_tdata[25:10]),
        .ctrl           (ctrl),
        .stat           (stat),
        .clear_busy     (clear_busy),
        .out_valid      (m_axis_tvalid),
        .out_ready      (m_axis_tready),
        .out_owner      (owner),
        .out_first      (first_b),
        .out_last_block (last_b),
        .out_success    (success),
        .out_last       (m_axis_tlast)
    );

    assign m_axis_tdata = {3'b000, success, last_b, first_b, owner};

    a_no_accept_when_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        busy |-> !s_axis_tready) else $error("accept while busy");
    a_idle_no_out: assert property (@(posedge aclk) disable iff (!aresetn)
        $past(clear_busy) |-> !m_axis_tvalid) else $error("output during clear");
    a_fail_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_axis_tvalid && !success) |-> (owner == '0 && m_axis_tlast))
        else $error("failed result not zero");
endmodule : contiguous_block_allocator
`default_nettype wire

/* dv/tb_contiguous_block_allocator.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_contiguous_block_allocator
// Self-checking bench for the contiguous block allocator: a queue-fed driver
// sends add, get, delete and defragment commands, an internal block map
// predicts every result beat, and a monitor compares them in order.
// ----------------------------------------------------------------------------
module tb_contiguous_block_allocator;
    import cba_pkg::*;

    localparam int NBLK = 64;
    localparam int MAX_RUNS = 64;
    localparam longint CYCLE_LIMIT = 2000000;

    typedef struct packed {
        logic [SIZE_W-1:0] size_kb;
        logic [ID_W-1:0]   file_id;
        mode_t             mode;
    } cmd_t;

    typedef struct packed {
        logic [7:0] owner;
        logic [5:0] first_block;
        logic [5:0] last_block;
        logic       success;
        logic       last;
    } alloc_res_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_axis_tvalid = 1'b0;
    logic s_axis_tready;
    logic [31:0] s_axis_tdata = '0;
    logic m_axis_tvalid;
    logic m_axis_tready = 1'b0;
    logic [23:0] m_axis_tdata;
    logic m_axis_tlast;

    cmd_t cmd_q[$];
    alloc_res_t exp_q[$];
    logic [7:0] blk_map[NBLK];
    int errors = 0;
    bit stim_done = 0;
    bit quiet = 0;
    bit hold_req = 0;
    bit hold_done = 0;
    longint cycles = 0;
    int s_gap = 0;
    int m_gap = 0;
    int hold_cnt = 0;

    contiguous_block_allocator #(.NUM_BLOCKS(NBLK)) u_top (
        .aclk(aclk), .aresetn(aresetn),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata), .m_axis_tlast(m_axis_tlast)
    );

    always #4 aclk = ~aclk;

    function automatic alloc_res_t mk_res(logic [7:0] o, int f, int l, logic ok);
        alloc_res_t r;
        r.owner = o;
        r.first_block = f[5:0];
        r.last_block = l[5:0];
        r.success = ok;
        r.last = 1'b1;
        return r;
    endfunction

    function automatic void push_runs();
        int j;
        int start;
        int n;
        logic [7:0] id;
        alloc_res_t r;
        j = 0;
        n = 0;
        while (j < NBLK) begin
            id = blk_map[j];
            if (id == 0) begin
                j++;
            end else begin
                start = j;
                while (j < NBLK && blk_map[j] == id) j++;
                if (n < MAX_RUNS) begin
                    r = mk_res(id, start, j - 1, 1'b1);
                    r.last = 1'b0;
                    exp_q.push_back(r);
                    n++;
                end
            end
        end
        if (n > 0) exp_q[$].last = 1'b1;
    endfunction

    function automatic void predict_alloc(cmd_t c);
        int need;
        int run;
        int start;
        int j;
        int w;
        bit found;
        found = 0;
        start = 0;
        case (c.mode)
            MODE_ADD: begin
                need = (int'(c.size_kb) + 7) / 8;
                run = 0;
                if (c.size_kb != 0 && c.file_id != 0 && need <= NBLK) begin
                    for (j = 0; j < NBLK && !found; j++) begin
                        run = (blk_map[j] == 0) ? run + 1 : 0;
                        if (run == need) begin
                            start = j + 1 - need;
                            found = 1;
                        end
                    end
                end
                if (found) begin
                    for (j = start; j < start + need; j++) blk_map[j] = c.file_id;
                    exp_q.push_back(mk_res(c.file_id, start, start + need - 1, 1'b1));
                end else begin
                    exp_q.push_back(mk_res(8'd0, 0, 0, 1'b0));
                end
            end
            MODE_GET: begin
                for (j = 0; j < NBLK && c.file_id != 0 && !found; j++) begin
                    if (blk_map[j] == c.file_id) begin
                        start = j;
                        found = 1;
                        while (j + 1 < NBLK && blk_map[j + 1] == c.file_id) j++;
                        exp_q.push_back(mk_res(c.file_id, start, j, 1'b1));
                    end
                end
                if (!found) exp_q.push_back(mk_res(8'd0, 0, 0, 1'b0));
            end
            MODE_DELETE: begin
                for (j = 0; j < NBLK; j++)
                    if (blk_map[j] == c.file_id) blk_map[j] = 8'd0;
                push_runs();
            end
            default: begin
                w = 0;
                for (j = 0; j < NBLK; j++) begin
                    if (blk_map[j] != 0) begin
                        blk_map[w] = blk_map[j];
                        w++;
                    end
                end
                for (; w < NBLK; w++) blk_map[w] = 8'd0;
                push_runs();
            end
        endcase
    endfunction

    function automatic cmd_t mk_cmd(mode_t m, int id, int sz);
        cmd_t c;
        c.mode = m;
        c.file_id = id[7:0];
        c.size_kb = sz[15:0];
        return c;
    endfunction

    // driver
    always @(posedge aclk) begin
        cmd_t c;
        cycles <= cycles + 1;
        if (aresetn) begin
            if (s_axis_tvalid && s_axis_tready) begin
                c = cmd_t'(s_axis_tdata[25:0]);
                predict_alloc(c);
            end
            if (s_axis_tvalid && !s_axis_tready) begin
            end else if (s_gap > 0) begin
                s_gap <= s_gap - 1;
                s_axis_tvalid <= 1'b0;
            end else if (cmd_q.size() > 0) begin
                if (!quiet && $urandom_range(0, 7) == 0) begin
                    s_gap <= $urandom_range(1, 17);
                    s_axis_tvalid <= 1'b0;
                end else begin
                    c = cmd_q.pop_front();
                    s_axis_tdata <= {6'd0, c};
                    s_axis_tvalid <= 1'b1;
                end
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    // monitor
    always @(posedge aclk) begin
        alloc_res_t got;
        alloc_res_t want;
        if (aresetn) begin
            if (m_axis_tvalid && m_axis_tready) begin
                got.owner = m_axis_tdata[7:0];
                got.first_block = m_axis_tdata[13:8];
                got.last_block = m_axis_tdata[19:14];
                got.success = m_axis_tdata[20];
                got.last = m_axis_tlast;
                if (exp_q.size() == 0) begin
                    $error("unexpected result beat %p", got);
                    errors++;
                end else begin
                    want = exp_q.pop_front();
                    if (got.owner != want.owner) begin
                        $error("owner exp %0d got %0d", want.owner, got.owner);
                        errors++;
                    end
                    if (got.first_block != want.first_block) begin
                        $error("first_block exp %0d got %0d", want.first_block,
                               got.first_block);
                        errors++;
                    end
                    if (got.last_block != want.last_block) begin
                        $error("last_block exp %0d got %0d", want.last_block,
                               got.last_block);
                        errors++;
                    end
                    if (got.success != want.success) begin
                        $error("success exp %0d got %0d", want.success, got.success);
                        errors++;
                    end
                    if (got.last != want.last) begin
                        $error("last exp %0d got %0d", want.last, got.last);
                        errors++;
                    end
                end
            end
            if (hold_req && !hold_done && hold_cnt == 0) begin
                hold_cnt <= 3000;
                hold_done <= 1'b1;
                m_axis_tready <= 1'b0;
            end else if (hold_cnt > 1) begin
                hold_cnt <= hold_cnt - 1;
            end else if (hold_cnt == 1) begin
                hold_cnt <= 0;
                m_axis_tready <= 1'b1;
            end else if (m_gap > 0) begin
                m_gap <= m_gap - 1;
                m_axis_tready <= (m_gap == 1);
            end else if (!quiet && $urandom_range(0, 9) == 0) begin
                m_gap <= $urandom_range(1, 17);
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    task automatic wait_drained();
        while (cmd_q.size() > 0 || s_axis_tvalid || exp_q.size() > 0) @(posedge aclk);
    endtask

    initial begin
        int i;
        int r;
        for (i = 0; i < NBLK; i++) blk_map[i] = 8'd0;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;

        // directed
        cmd_q.push_back(mk_cmd(MODE_DELETE, 0, 0));
        cmd_q.push_back(mk_cmd(MODE_DEFRAG, 0, 0));
        cmd_q.push_back(mk_cmd(MODE_ADD, 1, 0));
        cmd_q.push_back(mk_cmd(MODE_ADD, 0, 8));
        cmd_q.push_back(mk_cmd(MODE_ADD, 2, 65535));
        cmd_q.push_back(mk_cmd(MODE_ADD, 3, 513));
        cmd_q.push_back(mk_cmd(MODE_ADD, 4, 512));
        cmd_q.push_back(mk_cmd(MODE_GET, 4, 0));
        cmd_q.push_back(mk_cmd(MODE_ADD, 5, 1));
        cmd_q.push_back(mk_cmd(MODE_DELETE, 4, 0));
        cmd_q.push_back(mk_cmd(MODE_GET, 0, 0));
        cmd_q.push_back(mk_cmd(MODE_GET, 9, 0));
        cmd_q.push_back(mk_cmd(MODE_ADD, 255, 9));
        cmd_q.push_back(mk_cmd(MODE_ADD, 7, 8));
        cmd_q.push_back(mk_cmd(MODE_ADD, 255, 16));
        cmd_q.push_back(mk_cmd(MODE_DELETE, 7, 0));
        cmd_q.push_back(mk_cmd(MODE_GET, 255, 0));
        cmd_q.push_back(mk_cmd(MODE_DEFRAG, 0, 0));
        cmd_q.push_back(mk_cmd(MODE_DELETE, 0, 0));
        cmd_q.push_back(mk_cmd(MODE_DELETE, 255, 0));
        for (i = 0; i < 64; i++) cmd_q.push_back(mk_cmd(MODE_ADD, 1 + (i % 2), 7));
        cmd_q.push_back(mk_cmd(MODE_DEFRAG, 0, 0));
        hold_req = 1;
        wait_drained();
        hold_req = 0;
        cmd_q.push_back(mk_cmd(MODE_DELETE, 1, 0));
        cmd_q.push_back(mk_cmd(MODE_DELETE, 2, 0));

        // random, mostly small files over a few ids
        for (i = 0; i < 130; i++) begin
            r = $urandom_range(0, 99);
            if (i == 90) begin
                while (cmd_q.size() > 0 || s_axis_tvalid) @(posedge aclk);
                quiet = 1;
            end
            if (r < 45)
                cmd_q.push_back(mk_cmd(MODE_ADD,
                    ($urandom_range(0, 19) == 0) ? $urandom_range(0, 255)
                                                 : $urandom_range(1, 12),
                    ($urandom_range(0, 15) == 0) ? $urandom_range(0, 65535)
                                                 : $urandom_range(0, 80)));
            else if (r < 65)
                cmd_q.push_back(mk_cmd(MODE_GET, $urandom_range(0, 14), $urandom));
            else if (r < 90)
                cmd_q.push_back(mk_cmd(MODE_DELETE, $urandom_range(0, 14), $urandom));
            else
                cmd_q.push_back(mk_cmd(MODE_DEFRAG, $urandom_range(0, 255), $urandom));
        end
        cmd_q.push_back(mk_cmd(MODE_ADD, 8'hAA, 16'hAAAA));
        cmd_q.push_back(mk_cmd(MODE_GET, 8'h55, 16'h5555));
        stim_done = 1;
    end

    initial begin
        wait (stim_done);
        while (cmd_q.size() > 0 || s_axis_tvalid || exp_q.size() > 0) @(posedge aclk);
        repeat (300) @(posedge aclk);
        if (errors == 0) begin
            $display("tb_contiguous_block_allocator: done, clean");
        end else begin
            $display("tb_contiguous_block_allocator: done, errors");
        end
        $finish;
    end

    initial begin
        wait (cycles >= CYCLE_LIMIT);
        $display("tb_contiguous_block_allocator: done, errors");
        $finish;
    end

endmodule
